@@ design/lru_writeback_cache_set_replacement_unit_assert.svh @@
// assertion macros for the lru set replacement unit
`ifndef LRU_WRITEBACK_CACHE_SET_REPLACEMENT_UNIT_ASSERT_SVH
`define LRU_WRITEBACK_CACHE_SET_REPLACEMENT_UNIT_ASSERT_SVH

// same-cycle implication
`define LRU_ASSERT_IMPLY(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("lru unit check failed");

// next-cycle implication
`define LRU_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("lru unit check failed");

`endif

@@ design/lru_pkg.sv @@
// shared types and constants of the lru set replacement unit
`timescale 1ns / 1ps

package lru_pkg;

  localparam int unsigned SET_IDX_W  = 8;
  localparam int unsigned TAG_W      = 24;
  localparam int unsigned STATUS_W   = 3;
  localparam int unsigned WAY_W      = 2;
  localparam int unsigned ADDR_W     = 32;
  localparam int unsigned CNT_W      = 32;
  localparam int unsigned SHIFT_W    = 5;
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 5;
  localparam int unsigned SET_SPAN   = 1 << SET_IDX_W;

  localparam int unsigned SETS_DEF     = 256;
  localparam int unsigned WAYS_DEF     = 4;
  localparam int unsigned TAG_BITS_DEF = 24;

  localparam logic [SHIFT_W-1:0] TAG_SHIFT_RST   = 5'd14;
  localparam logic [SHIFT_W-1:0] BLOCK_SHIFT_RST = 5'd6;

  typedef enum logic {
    OP_TOUCH = 1'b0,
    OP_FILL  = 1'b1
  } lru_op_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_TOUCHED = 3'd0,
    ST_FILLED  = 3'd1,
    ST_CLEAN   = 3'd2,
    ST_DIRTY   = 3'd3,
    ST_MISS    = 3'd4
  } lru_status_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TAG_SHIFT   = 1'b0,
    CFG_BLOCK_SHIFT = 1'b1
  } lru_cfg_e;

  typedef struct packed {
    lru_status_e       status;
    logic [WAY_W-1:0]  way;
    logic              wb_valid;
    logic [ADDR_W-1:0] wb_addr;
  } lru_result_t;

endpackage

@@ design/lru_ram.sv @@
// generic single-write, single-read ram with registered read data
`timescale 1ns / 1ps

module lru_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ design/lru_way_logic.sv @@
// per-set tag match, victim choice and recency update for one item
`timescale 1ns / 1ps

module lru_way_logic
  import lru_pkg::*;
#(
  parameter int unsigned WAYS = WAYS_DEF,
  parameter int unsigned TSW  = TAG_BITS_DEF,
  parameter int unsigned SW   = SET_IDX_W,
  localparam int unsigned WW  = (WAYS > 1) ? $clog2(WAYS) : 1,
  localparam int unsigned AW  = (WAYS > 1) ? $clog2(WAYS) : 1,
  localparam int unsigned RW  = WAYS * (TSW + AW + 2)
) (
  input  lru_op_e            op_i,
  input  logic [SW-1:0]      set_i,
  input  logic [TSW-1:0]     tag_i,
  input  logic               is_write_i,
  input  logic [SHIFT_W-1:0] tag_shift_i,
  input  logic [SHIFT_W-1:0] block_shift_i,
  input  logic [RW-1:0]      row_i,
  output logic [RW-1:0]      row_o,
  output lru_result_t        result_o
);

  localparam int unsigned VB = WAYS * TSW;
  localparam int unsigned DB = VB + WAYS;
  localparam int unsigned AB = DB + WAYS;

  logic [TSW-1:0] tags   [WAYS];
  logic [AW-1:0]  ages   [WAYS];
  logic [WAYS-1:0] valid;
  logic [WAYS-1:0] dirty;

  logic [TSW-1:0] tags_n [WAYS];
  logic [AW-1:0]  ages_n [WAYS];
  logic [WAYS-1:0] valid_n;
  logic [WAYS-1:0] dirty_n;

  logic          hit;
  logic [WW-1:0] hit_way;
  logic          empty;
  logic [WW-1:0] empty_way;
  logic [AW-1:0] best_age;
  logic [WW-1:0] victim_way;
  logic [WW-1:0] sel_way;
  logic          do_update;
  logic [AW:0]   old_age;
  logic          wb_valid;

  always_comb begin
    for (int j = 0; j < WAYS; j++) begin
      tags[j]  = row_i[j*TSW +: TSW];
      valid[j] = row_i[VB + j];
      dirty[j] = row_i[DB + j];
      ages[j]  = row_i[AB + j*AW +: AW];
    end
  end

  // lowest matching valid way, lowest empty way, oldest way
  always_comb begin
    hit        = 1'b0;
    hit_way    = '0;
    empty      = 1'b0;
    empty_way  = '0;
    best_age   = '0;
    victim_way = '0;
    for (int j = 0; j < WAYS; j++) begin
      if (!hit && valid[j] && (tags[j] == tag_i)) begin
        hit     = 1'b1;
        hit_way = WW'(j);
      end
      if (!empty && !valid[j]) begin
        empty     = 1'b1;
        empty_way = WW'(j);
      end
      if (ages[j] > best_age) begin
        best_age   = ages[j];
        victim_way = WW'(j);
      end
    end
  end

  always_comb begin
    if (op_i == OP_FILL) begin
      sel_way = empty ? empty_way : victim_way;
    end else begin
      sel_way = hit_way;
    end
    do_update = (op_i == OP_FILL) || hit;
    wb_valid  = (op_i == OP_FILL) && !empty && dirty[victim_way];
    old_age   = valid[sel_way] ? {1'b0, ages[sel_way]} : (AW+1)'(WAYS);
  end

  always_comb begin
    for (int j = 0; j < WAYS; j++) begin
      tags_n[j]  = tags[j];
      ages_n[j]  = ages[j];
      valid_n[j] = valid[j];
      dirty_n[j] = dirty[j];
      if (do_update) begin
        if (WW'(j) == sel_way) begin
          ages_n[j] = '0;
          if (op_i == OP_FILL) begin
            tags_n[j]  = tag_i;
            valid_n[j] = 1'b1;
            dirty_n[j] = is_write_i;
          end else begin
            dirty_n[j] = dirty[j] | is_write_i;
          end
        end else if (valid[j] && ({1'b0, ages[j]} < old_age)) begin
          ages_n[j] = ages[j] + 1'b1;
        end
      end
    end
  end

  always_comb begin
    row_o = '0;
    for (int j = 0; j < WAYS; j++) begin
      row_o[j*TSW +: TSW]   = tags_n[j];
      row_o[VB + j]         = valid_n[j];
      row_o[DB + j]         = dirty_n[j];
      row_o[AB + j*AW +: AW] = ages_n[j];
    end
  end

  always_comb begin
    result_o.way      = WAY_W'(sel_way);
    result_o.wb_valid = wb_valid;
    result_o.wb_addr  = '0;
    if (op_i == OP_TOUCH) begin
      result_o.status = hit ? ST_TOUCHED : ST_MISS;
    end else if (empty) begin
      result_o.status = ST_FILLED;
    end else if (wb_valid) begin
      result_o.status  = ST_DIRTY;
      result_o.wb_addr = (ADDR_W'(tags[victim_way]) << tag_shift_i)
                       | (ADDR_W'(set_i) << block_shift_i);
    end else begin
      result_o.status = ST_CLEAN;
    end
  end

endmodule

@@ design/lru_writeback_cache_set_replacement_unit.sv @@
// top level: lru replacement state for a set-associative write-back cache
// an item is registered with its set ram read, its result is registered at the output
// one item per cycle unless output stalls, same-set back-to-back items use a row bypass
// the set row lives in a ram with registered read, one read and one write port
// reset clears the per-set row marks and the write-back count, loads the shift defaults
// there is no clearing pass, items are taken from the first cycle after reset
`timescale 1ns / 1ps

`include "lru_writeback_cache_set_replacement_unit_assert.svh"

module lru_writeback_cache_set_replacement_unit
  import lru_pkg::*;
#(
  parameter int unsigned SETS     = SETS_DEF,
  parameter int unsigned WAYS     = WAYS_DEF,
  parameter int unsigned TAG_BITS = TAG_BITS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,

  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,

  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic                  operation_i,
  input  logic [SET_IDX_W-1:0]  set_index_i,
  input  logic [TAG_W-1:0]      tag_i,
  input  logic                  is_write_i,

  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic [STATUS_W-1:0]   status_o,
  output logic [WAY_W-1:0]      way_used_o,
  output logic                  writeback_valid_o,
  output logic [ADDR_W-1:0]     writeback_address_o,
  output logic [CNT_W-1:0]      writeback_total_o
);

  localparam int unsigned ROWS = (SETS < SET_SPAN) ? SETS : SET_SPAN;
  localparam int unsigned SW   = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int unsigned TSW  = (TAG_BITS < TAG_W) ? TAG_BITS : TAG_W;
  localparam int unsigned AW   = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int unsigned RW   = WAYS * (TSW + AW + 2);

  logic [SHIFT_W-1:0] tag_shift_q;
  logic [SHIFT_W-1:0] block_shift_q;

  logic [SW-1:0] set_map [SET_SPAN];
  logic [SW-1:0] in_set;

  logic          in_acc;
  logic          s_fire;
  logic          out_take;

  logic          s_valid_q;
  lru_op_e       s_op_q;
  logic [SW-1:0] s_set_q;
  logic [TSW-1:0] s_tag_q;
  logic          s_wr_q;
  logic          s_init_q;
  logic          s_fwd_q;

  logic [ROWS-1:0] row_init_q;
  logic [RW-1:0]   last_row_q;
  logic [RW-1:0]   ram_rdata;
  logic [RW-1:0]   row_cur;
  logic [RW-1:0]   row_new;
  lru_result_t     result;

  logic [CNT_W-1:0] wb_cnt_q;
  logic [CNT_W-1:0] wb_cnt_d;

  logic          o_valid_q;
  lru_result_t   o_result_q;
  logic [CNT_W-1:0] o_total_q;

  // set index taken modulo the set count
  for (genvar i = 0; i < SET_SPAN; i++) begin : g_set_map
    assign set_map[i] = SW'(i % SETS);
  end
  assign in_set = set_map[set_index_i];

  assign s_fire     = s_valid_q && (!o_valid_q || !out_stall_i);
  assign in_stall_o = s_valid_q && !s_fire;
  assign in_acc     = in_valid_i && !in_stall_o;
  assign out_take   = o_valid_q && !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tag_shift_q   <= TAG_SHIFT_RST;
      block_shift_q <= BLOCK_SHIFT_RST;
    end else if (cfg_we_i) begin
      unique case (lru_cfg_e'(cfg_idx_i))
        CFG_TAG_SHIFT:   tag_shift_q   <= cfg_data_i;
        CFG_BLOCK_SHIFT: block_shift_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  lru_ram #(
    .WIDTH (RW),
    .DEPTH (ROWS)
  ) u_row_ram (
    .clk_i   (clk_i),
    .we_i    (s_fire),
    .waddr_i (s_set_q),
    .wdata_i (row_new),
    .re_i    (in_acc),
    .raddr_i (in_set),
    .rdata_o (ram_rdata)
  );

  // stage control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_valid_q  <= 1'b0;
      s_fwd_q    <= 1'b0;
      row_init_q <= '0;
    end else begin
      if (in_acc) begin
        s_valid_q <= 1'b1;
        s_fwd_q   <= s_fire && (s_set_q == in_set);
      end else if (s_fire) begin
        s_valid_q <= 1'b0;
        s_fwd_q   <= 1'b0;
      end
      if (s_fire) begin
        row_init_q[s_set_q] <= 1'b1;
      end
    end
  end

  // stage payload
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s_op_q   <= lru_op_e'(operation_i);
      s_set_q  <= in_set;
      s_tag_q  <= tag_i[TSW-1:0];
      s_wr_q   <= is_write_i;
      s_init_q <= row_init_q[in_set];
    end
    if (s_fire) begin
      last_row_q <= row_new;
    end
  end

  always_comb begin
    if (s_fwd_q) begin
      row_cur = last_row_q;
    end else if (s_init_q) begin
      row_cur = ram_rdata;
    end else begin
      row_cur = '0;
    end
  end

  lru_way_logic #(
    .WAYS (WAYS),
    .TSW  (TSW),
    .SW   (SW)
  ) u_way_logic (
    .op_i          (s_op_q),
    .set_i         (s_set_q),
    .tag_i         (s_tag_q),
    .is_write_i    (s_wr_q),
    .tag_shift_i   (tag_shift_q),
    .block_shift_i (block_shift_q),
    .row_i         (row_cur),
    .row_o         (row_new),
    .result_o      (result)
  );

  assign wb_cnt_d = wb_cnt_q + CNT_W'(result.wb_valid);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wb_cnt_q  <= '0;
      o_valid_q <= 1'b0;
    end else begin
      if (s_fire) begin
        wb_cnt_q  <= wb_cnt_d;
        o_valid_q <= 1'b1;
      end else if (out_take) begin
        o_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_fire) begin
      o_result_q <= result;
      o_total_q  <= wb_cnt_d;
    end
  end

  assign out_valid_o         = o_valid_q;
  assign status_o            = o_result_q.status;
  assign way_used_o          = o_result_q.way;
  assign writeback_valid_o   = o_result_q.wb_valid;
  assign writeback_address_o = o_result_q.wb_addr;
  assign writeback_total_o   = o_total_q;

  `LRU_ASSERT_NEXT(a_fire_gives_result, s_fire, out_valid_o)
  `LRU_ASSERT_NEXT(a_count_holds_idle, !s_fire, $stable(wb_cnt_q))
  `LRU_ASSERT_IMPLY(a_wb_means_dirty, out_valid_o && writeback_valid_o,
                    o_result_q.status == ST_DIRTY)
  `LRU_ASSERT_IMPLY(a_bypass_needs_item, s_fwd_q, s_valid_q)

endmodule

@@ tb/tb_lru_writeback_cache_set_replacement_unit.sv @@
// testbench for the lru set replacement unit: predicts each outcome and compares it field by field
`timescale 1ns / 1ps

module tb_lru_writeback_cache_set_replacement_unit;
  import lru_pkg::*;

  localparam int WATCHDOG_LIMIT = 1000;
  localparam int HOLD_CYCLES    = 80;
  localparam int PHASE_ITEMS    = 240;
  localparam int PHASES         = 8;

  typedef struct {
    lru_status_e       status;
    logic [WAY_W-1:0]  way;
    logic              wb_valid;
    logic [ADDR_W-1:0] wb_addr;
    logic [CNT_W-1:0]  wb_total;
  } cache_outcome_t;

  class lru_set_tracker;
    bit [TAG_W-1:0]   tags [SETS_DEF][WAYS_DEF];
    bit               valid [SETS_DEF][WAYS_DEF];
    bit               dirty [SETS_DEF][WAYS_DEF];
    bit [1:0]         age [SETS_DEF][WAYS_DEF];
    bit [CNT_W-1:0]   wb_count;
    bit [SHIFT_W-1:0] tag_sh;
    bit [SHIFT_W-1:0] blk_sh;
    cache_outcome_t   outcome_q[$];
    int               errors;

    function new();
      tag_sh   = TAG_SHIFT_RST;
      blk_sh   = BLOCK_SHIFT_RST;
      wb_count = '0;
      errors   = 0;
    endfunction

    function void write_shift(lru_cfg_e idx, bit [SHIFT_W-1:0] val);
      if (idx == CFG_TAG_SHIFT) begin
        tag_sh = val;
      end else begin
        blk_sh = val;
      end
    endfunction

    // make way w the most recent line of set s
    function void promote(int s, int w);
      int old;
      old = valid[s][w] ? int'(age[s][w]) : WAYS_DEF;
      for (int j = 0; j < WAYS_DEF; j++) begin
        if (j != w && valid[s][j] && int'(age[s][j]) < old) begin
          age[s][j] = age[s][j] + 2'd1;
        end
      end
      age[s][w] = 2'd0;
    endfunction

    function void note_access(lru_op_e op, bit [SET_IDX_W-1:0] s, bit [TAG_W-1:0] t, bit wr);
      cache_outcome_t r;
      int             w;
      bit             found;
      bit [1:0]       best;
      bit [63:0]      a;
      r.status   = ST_TOUCHED;
      r.way      = '0;
      r.wb_valid = 1'b0;
      r.wb_addr  = '0;
      w          = 0;
      found      = 1'b0;
      if (op == OP_TOUCH) begin
        for (int j = 0; j < WAYS_DEF; j++) begin
          if (!found && valid[s][j] && tags[s][j] == t) begin
            found = 1'b1;
            w     = j;
          end
        end
        if (found) begin
          promote(s, w);
          if (wr) dirty[s][w] = 1'b1;
          r.status = ST_TOUCHED;
          r.way    = w[WAY_W-1:0];
        end else begin
          r.status = ST_MISS;
        end
      end else begin
        for (int j = 0; j < WAYS_DEF; j++) begin
          if (!found && !valid[s][j]) begin
            found = 1'b1;
            w     = j;
          end
        end
        if (found) begin
          r.status = ST_FILLED;
        end else begin
          best = 2'd0;
          w    = 0;
          for (int j = 0; j < WAYS_DEF; j++) begin
            if (age[s][j] > best) begin
              best = age[s][j];
              w    = j;
            end
          end
          if (dirty[s][w]) begin
            a = (64'(tags[s][w]) << tag_sh) | (64'(s) << blk_sh);
            r.wb_valid = 1'b1;
            r.wb_addr  = a[ADDR_W-1:0];
            wb_count   = wb_count + 1;
            r.status   = ST_DIRTY;
          end else begin
            r.status = ST_CLEAN;
          end
        end
        promote(s, w);
        tags[s][w]  = t;
        valid[s][w] = 1'b1;
        dirty[s][w] = wr;
        r.way       = w[WAY_W-1:0];
      end
      r.wb_total = wb_count;
      outcome_q.insert(outcome_q.size(), r);
    endfunction

    function void check_outcome(logic [STATUS_W-1:0] st, logic [WAY_W-1:0] w, logic wbv,
                                logic [ADDR_W-1:0] addr, logic [CNT_W-1:0] tot);
      cache_outcome_t r;
      if (outcome_q.size() == 0) begin
        $error("result with no item pending");
        errors++;
        return;
      end
      r = outcome_q.pop_front();
      if (st !== r.status) begin
        $error("status: expected %0d, actual %0d", r.status, st);
        errors++;
      end
      if (w !== r.way) begin
        $error("way_used: expected %0d, actual %0d", r.way, w);
        errors++;
      end
      if (wbv !== r.wb_valid) begin
        $error("writeback_valid: expected %0d, actual %0d", r.wb_valid, wbv);
        errors++;
      end
      if (addr !== r.wb_addr) begin
        $error("writeback_address: expected %h, actual %h", r.wb_addr, addr);
        errors++;
      end
      if (tot !== r.wb_total) begin
        $error("writeback_total: expected %0d, actual %0d", r.wb_total, tot);
        errors++;
      end
    endfunction

    function int pending_count();
      return outcome_q.size();
    endfunction
  endclass

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;
  logic                  in_valid_i;
  logic                  in_stall_o;
  logic                  operation_i;
  logic [SET_IDX_W-1:0]  set_index_i;
  logic [TAG_W-1:0]      tag_i;
  logic                  is_write_i;
  logic                  out_valid_o;
  logic                  out_stall_i;
  logic [STATUS_W-1:0]   status_o;
  logic [WAY_W-1:0]      way_used_o;
  logic                  writeback_valid_o;
  logic [ADDR_W-1:0]     writeback_address_o;
  logic [CNT_W-1:0]      writeback_total_o;

  lru_set_tracker       sb;
  logic [SET_IDX_W-1:0] hot_sets[4];
  bit                   steady;
  bit                   hold_req;
  int                   quiet_cycles;

  lru_writeback_cache_set_replacement_unit u_top (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .cfg_we_i            (cfg_we_i),
    .cfg_idx_i           (cfg_idx_i),
    .cfg_data_i          (cfg_data_i),
    .in_valid_i          (in_valid_i),
    .in_stall_o          (in_stall_o),
    .operation_i         (operation_i),
    .set_index_i         (set_index_i),
    .tag_i               (tag_i),
    .is_write_i          (is_write_i),
    .out_valid_o         (out_valid_o),
    .out_stall_i         (out_stall_i),
    .status_o            (status_o),
    .way_used_o          (way_used_o),
    .writeback_valid_o   (writeback_valid_o),
    .writeback_address_o (writeback_address_o),
    .writeback_total_o   (writeback_total_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // mostly hot sets, touches mostly hit, some fills reuse a present tag
  function automatic void pick_random(output lru_op_e op, output logic [SET_IDX_W-1:0] s,
                                      output logic [TAG_W-1:0] t, output logic wr);
    int ways_on[$];
    int k;
    s  = ($urandom_range(0, 3) == 0) ? SET_IDX_W'($urandom()) : hot_sets[$urandom_range(0, 3)];
    wr = 1'($urandom_range(0, 1));
    t  = TAG_W'($urandom());
    for (int j = 0; j < WAYS_DEF; j++) begin
      if (sb.valid[s][j]) ways_on.insert(ways_on.size(), j);
    end
    if ($urandom_range(0, 99) < 55) begin
      op = OP_TOUCH;
      if (ways_on.size() > 0 && $urandom_range(0, 3) != 0) begin
        t = sb.tags[s][ways_on[$urandom_range(0, ways_on.size() - 1)]];
      end
    end else begin
      op = OP_FILL;
      k  = $urandom_range(0, 9);
      if (k < 2 && ways_on.size() > 0) begin
        t = sb.tags[s][ways_on[$urandom_range(0, ways_on.size() - 1)]];
      end else if (k == 2) begin
        t = $urandom_range(0, 1) ? '0 : '1;
      end
    end
  endfunction

  task automatic send_item(bit random_pick, lru_op_e op, logic [SET_IDX_W-1:0] s,
                           logic [TAG_W-1:0] t, logic wr);
    int gap;
    gap = steady ? 0 : $urandom_range(0, 12);
    @(negedge clk_i);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    if (random_pick) pick_random(op, s, t, wr);
    operation_i <= op;
    set_index_i <= s;
    tag_i       <= t;
    is_write_i  <= wr;
    in_valid_i  <= 1'b1;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  task automatic drain_and_configure(logic [SHIFT_W-1:0] tsh, logic [SHIFT_W-1:0] bsh);
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (sb.pending_count() != 0) @(posedge clk_i);
    repeat (4) @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= CFG_TAG_SHIFT;
    cfg_data_i <= tsh;
    sb.write_shift(CFG_TAG_SHIFT, tsh);
    @(negedge clk_i);
    cfg_idx_i  <= CFG_BLOCK_SHIFT;
    cfg_data_i <= bsh;
    sb.write_shift(CFG_BLOCK_SHIFT, bsh);
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // receiver side
  initial begin
    int w;
    out_stall_i = 1'b0;
    forever begin
      w = steady ? 0 : $urandom_range(0, 12);
      if (hold_req) begin
        hold_req = 1'b0;
        w        = HOLD_CYCLES;
      end
      @(negedge clk_i);
      if (w > 0) begin
        out_stall_i <= 1'b1;
        repeat (w) @(negedge clk_i);
      end
      out_stall_i <= 1'b0;
      do @(posedge clk_i); while (!out_valid_o);
    end
  end

  // accepted items and results
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        sb.note_access(lru_op_e'(operation_i), set_index_i, tag_i, is_write_i);
      end
      if (out_valid_o && !out_stall_i) begin
        sb.check_outcome(status_o, way_used_o, writeback_valid_o, writeback_address_o,
                         writeback_total_o);
      end
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  initial begin
    logic [SHIFT_W-1:0] tag_cfg[PHASES];
    logic [SHIFT_W-1:0] blk_cfg[PHASES];
    sb           = new();
    steady       = 1'b0;
    hold_req     = 1'b0;
    quiet_cycles = 0;
    rst_ni       = 1'b0;
    cfg_we_i     = 1'b0;
    cfg_idx_i    = CFG_TAG_SHIFT;
    cfg_data_i   = '0;
    in_valid_i   = 1'b0;
    operation_i  = OP_TOUCH;
    set_index_i  = '0;
    tag_i        = '0;
    is_write_i   = 1'b0;
    tag_cfg = '{5'd14, 5'd0, 5'd31, 5'd31, 5'd0, SHIFT_W'($urandom()), SHIFT_W'($urandom()), 5'd8};
    blk_cfg = '{5'd6, 5'd0, 5'd31, 5'd0, 5'd31, SHIFT_W'($urandom()), SHIFT_W'($urandom()), 5'd0};
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed: empty fills, duplicate tag, lowest-way match, miss, clean and dirty evictions
    send_item(0, OP_TOUCH, 8'h00, 24'h000000, 1'b0);
    send_item(0, OP_FILL,  8'h00, 24'h000000, 1'b1);
    send_item(0, OP_FILL,  8'h00, 24'hFFFFFF, 1'b0);
    send_item(0, OP_FILL,  8'h00, 24'h123456, 1'b0);
    send_item(0, OP_FILL,  8'h00, 24'h000000, 1'b0);
    send_item(0, OP_TOUCH, 8'h00, 24'h000000, 1'b0);
    send_item(0, OP_TOUCH, 8'h00, 24'hFFFFFF, 1'b1);
    send_item(0, OP_TOUCH, 8'h00, 24'hABCDEF, 1'b1);
    send_item(0, OP_FILL,  8'h00, 24'h777777, 1'b0);
    send_item(0, OP_FILL,  8'h00, 24'h000001, 1'b1);
    send_item(0, OP_FILL,  8'h00, 24'h000002, 1'b1);
    send_item(0, OP_FILL,  8'h00, 24'h000003, 1'b1);
    send_item(0, OP_FILL,  8'h00, 24'h000004, 1'b0);
    send_item(0, OP_TOUCH, 8'hFF, 24'hFFFFFF, 1'b0);
    send_item(0, OP_FILL,  8'hFF, 24'hFFFFFF, 1'b1);
    send_item(0, OP_TOUCH, 8'hFF, 24'hFFFFFF, 1'b0);
    send_item(0, OP_FILL,  8'hFF, 24'h000000, 1'b1);
    send_item(0, OP_FILL,  8'hFF, 24'h5A5A5A, 1'b1);
    send_item(0, OP_FILL,  8'hFF, 24'hA5A5A5, 1'b1);
    send_item(0, OP_FILL,  8'hFF, 24'h000010, 1'b0);
    send_item(0, OP_FILL,  8'hFF, 24'h000011, 1'b0);

    for (int ph = 0; ph < PHASES; ph++) begin
      drain_and_configure(tag_cfg[ph], blk_cfg[ph]);
      steady      = (ph == 4);
      hot_sets[0] = 8'h00;
      hot_sets[1] = 8'hFF;
      hot_sets[2] = SET_IDX_W'($urandom());
      hot_sets[3] = SET_IDX_W'($urandom());
      if (ph == 2) hold_req = 1'b1;
      repeat (PHASE_ITEMS) send_item(1, OP_TOUCH, '0, '0, 1'b0);
    end

    @(negedge clk_i);
    in_valid_i <= 1'b0;
    steady = 1'b0;
    while (sb.pending_count() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending_count() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

@@ sim.f @@
+incdir+design
design/lru_pkg.sv
design/lru_ram.sv
design/lru_way_logic.sv
design/lru_writeback_cache_set_replacement_unit.sv
tb/tb_lru_writeback_cache_set_replacement_unit.sv
